[hdl/rtt_pkg.sv]
// rtt_pkg: shared types and constants of the tcp rtt seq/ack matcher
// no dependencies; imported by rtt_cam and tcp_rtt_seq_ack_matcher
package rtt_pkg;

  // fixed widths of the tcp sequence numbers and the packet indices
  localparam int SEQ_W = 32;
  localparam int PKT_W = 32;

  // handshake progress of the current stream
  typedef enum logic [2:0] {
    PH_FIRST  = 3'b001,
    PH_SECOND = 3'b010,
    PH_STEADY = 3'b100
  } phase_t;

  // request from the control path to the key table
  typedef struct packed {
    logic             upd;
    logic             clear;
    logic             look_en;
    logic [SEQ_W-1:0] look_key;
    logic [SEQ_W-1:0] store_key;
  } cam_req_t;

endpackage

[hdl/tcp_rtt_seq_ack_matcher.sv]
// tcp_rtt_seq_ack_matcher: top level of the tcp rtt matcher
// depends on rtt_pkg, rtt_cam and rtt_ram
//
// Usage: packets of one tcp stream enter in order on the in_ channel
// (valid/ready); in_stream_start marks the first packet of a new stream
// and empties the table. The first two packets form the handshake and
// the second always yields one rtt item. Later packets with the ack flag
// look up their ack number; a match not yet acknowledged yields one item
// on the out_ channel. Every packet is then stored under its key.
// A result item passes the input stage, the result stage and the output
// register. Throughput: one packet per cycle while the receiver keeps up,
// set by the key compare and flag update in the key table (ram read of
// the matched slot follows in the next cycle); a packet without a result
// leaves nothing. Reset: the table, the counters and the handshake state
// are cleared; the first packet after reset starts a stream. A stalled
// receiver holds the result item; the block keeps taking packets until
// its two internal stages are full, then drops in_ready.
module tcp_rtt_seq_ack_matcher
  import rtt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64,
  parameter int TIME_BITS     = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_stream_start,
  input  logic [SEQ_W-1:0]     in_seq_number,
  input  logic [SEQ_W-1:0]     in_ack_number,
  input  logic                 in_ack_flag,
  input  logic [TIME_BITS-1:0] in_timestamp,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PKT_W-1:0]     out_message_index,
  output logic [PKT_W-1:0]     out_ack_index,
  output logic [SEQ_W-1:0]     out_matched_key,
  output logic [TIME_BITS-1:0] out_message_time,
  output logic [TIME_BITS-1:0] out_round_trip
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int RAM_W = TIME_BITS + PKT_W;

  // input stage
  logic                 a_valid_r;
  logic                 a_start_r;
  logic [SEQ_W-1:0]     a_seq_r;
  logic [SEQ_W-1:0]     a_ack_r;
  logic                 a_flag_r;
  logic [TIME_BITS-1:0] a_time_r;

  // result stage waiting for ram data
  logic                 b_valid_r;
  logic                 b_from_ram_r;
  logic [PKT_W-1:0]     b_msg_idx_r;
  logic [PKT_W-1:0]     b_ack_idx_r;
  logic [SEQ_W-1:0]     b_key_r;
  logic [TIME_BITS-1:0] b_msg_time_r;
  logic [TIME_BITS-1:0] b_ack_time_r;

  // output register
  logic                 c_valid_r;
  logic [PKT_W-1:0]     c_msg_idx_r;
  logic [PKT_W-1:0]     c_ack_idx_r;
  logic [SEQ_W-1:0]     c_key_r;
  logic [TIME_BITS-1:0] c_msg_time_r;
  logic [TIME_BITS-1:0] c_rtt_r;

  // stream state
  phase_t               phase_r, phase_nxt, phase_eff;
  logic [PKT_W-1:0]     count_r;
  logic [TIME_BITS-1:0] first_time_r;
  logic [SEQ_W-1:0]     first_key_r;

  logic                 a_adv, b_move;
  logic [PKT_W-1:0]     pkt_idx;
  logic                 is_hs;
  cam_req_t             cam_req;
  logic                 cam_hit;
  logic [IDX_W-1:0]     hit_idx, store_idx;
  logic [RAM_W-1:0]     ram_rd;
  logic [TIME_BITS-1:0] sel_msg_time;
  logic [PKT_W-1:0]     sel_msg_idx;

  // stage handshakes
  assign b_move   = b_valid_r && (!c_valid_r || out_ready);
  assign a_adv    = a_valid_r && (!b_valid_r || b_move);
  assign in_ready = !a_valid_r || a_adv;

  // per-packet decode
  assign phase_eff = a_start_r ? PH_FIRST : phase_r;
  assign pkt_idx   = a_start_r ? '0 : count_r;
  assign is_hs     = (phase_eff != PH_STEADY);

  always_comb begin
    cam_req.upd       = a_adv;
    cam_req.clear     = a_start_r;
    cam_req.look_en   = (phase_eff == PH_STEADY) && a_flag_r;
    cam_req.look_key  = a_ack_r;
    cam_req.store_key = is_hs ? a_seq_r + 1'b1 : a_seq_r;
  end

  rtt_cam #(
    .ENTRIES (TABLE_ENTRIES),
    .IDX_W   (IDX_W)
  ) u_cam (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (cam_req),
    .hit       (cam_hit),
    .hit_idx   (hit_idx),
    .store_idx (store_idx)
  );

  // time and packet number of each entry
  rtt_ram #(
    .WIDTH (RAM_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (a_adv),
    .wr_addr (store_idx),
    .wr_data ({a_time_r, pkt_idx}),
    .rd_en   (a_adv),
    .rd_addr (hit_idx),
    .rd_data (ram_rd)
  );

  // handshake progress
  always_comb begin
    phase_nxt = phase_eff;
    case (phase_eff)
      PH_FIRST:  phase_nxt = PH_SECOND;
      PH_SECOND: phase_nxt = PH_STEADY;
      PH_STEADY: phase_nxt = PH_STEADY;
      default:   phase_nxt = PH_FIRST;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      phase_r   <= PH_FIRST;
      count_r   <= '0;
    end else begin
      if (in_ready) begin
        a_valid_r <= in_valid;
      end
      if (a_adv) begin
        b_valid_r <= cam_hit || (phase_eff == PH_SECOND);
        phase_r   <= phase_nxt;
        count_r   <= pkt_idx + 1'b1;
      end else if (b_move) begin
        b_valid_r <= 1'b0;
      end
      if (b_move) begin
        c_valid_r <= 1'b1;
      end else if (out_ready) begin
        c_valid_r <= 1'b0;
      end
    end
  end

  // input payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_start_r <= in_stream_start;
      a_seq_r   <= in_seq_number;
      a_ack_r   <= in_ack_number;
      a_flag_r  <= in_ack_flag;
      a_time_r  <= in_timestamp;
    end
  end

  // first packet of the stream and the pending result
  always_ff @(posedge clk) begin
    if (a_adv) begin
      if (phase_eff == PH_FIRST) begin
        first_time_r <= a_time_r;
        first_key_r  <= a_seq_r + 1'b1;
      end
      b_from_ram_r <= !is_hs;
      b_msg_idx_r  <= '0;
      b_ack_idx_r  <= pkt_idx;
      b_key_r      <= is_hs ? first_key_r : a_ack_r;
      b_msg_time_r <= first_time_r;
      b_ack_time_r <= a_time_r;
    end
  end

  // steady-state results take the stored time and number from the ram
  assign sel_msg_time = b_from_ram_r ? ram_rd[RAM_W-1:PKT_W] : b_msg_time_r;
  assign sel_msg_idx  = b_from_ram_r ? ram_rd[PKT_W-1:0] : b_msg_idx_r;

  // output payload
  always_ff @(posedge clk) begin
    if (b_move) begin
      c_msg_idx_r  <= sel_msg_idx;
      c_ack_idx_r  <= b_ack_idx_r;
      c_key_r      <= b_key_r;
      c_msg_time_r <= sel_msg_time;
      c_rtt_r      <= b_ack_time_r - sel_msg_time;
    end
  end

  assign out_valid         = c_valid_r;
  assign out_message_index = c_msg_idx_r;
  assign out_ack_index     = c_ack_idx_r;
  assign out_matched_key   = c_key_r;
  assign out_message_time  = c_msg_time_r;
  assign out_round_trip    = c_rtt_r;

  // the second packet of a stream always produces a result
  a_hs_result: assert property (@(posedge clk) disable iff (!rst_n)
    (a_adv && phase_eff == PH_SECOND) |=> b_valid_r)
    else $error("handshake packet produced no result");

  // ram data must hold while its result waits
  a_ram_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && !b_move) |=> $stable(ram_rd))
    else $error("ram read data changed under a waiting result");

  // packet counter restarts at a new stream
  a_count_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (a_adv && a_start_r) |=> (count_r == PKT_W'(1)))
    else $error("packet counter did not restart");

endmodule

[hdl/rtt_ram.sv]
// rtt_ram: generic single write port ram with registered read-first read
// no dependencies
module rtt_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // read returns the old word when the same address is written
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/rtt_cam.sv]
// rtt_cam: key table with valid and acked flags, two parallel key lookups
// and fifo replacement; depends on rtt_pkg
module rtt_cam
  import rtt_pkg::*;
#(
  parameter int ENTRIES = 64,
  parameter int IDX_W   = $clog2(ENTRIES)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cam_req_t         req,
  output logic             hit,
  output logic [IDX_W-1:0] hit_idx,
  output logic [IDX_W-1:0] store_idx
);

  logic [ENTRIES-1:0] valid_r, valid_nxt, valid_eff;
  logic [ENTRIES-1:0] acked_r, acked_nxt, acked_eff;
  logic [IDX_W-1:0]   ptr_r, ptr_nxt, ptr_eff;
  logic [SEQ_W-1:0]   key_r [ENTRIES];
  logic [ENTRIES-1:0] look_match, store_match;
  logic [IDX_W-1:0]   look_idx, match_idx;
  logic               store_found;

  // a new stream sees an empty table
  assign valid_eff = req.clear ? '0 : valid_r;
  assign acked_eff = req.clear ? '0 : acked_r;
  assign ptr_eff   = req.clear ? '0 : ptr_r;

  // parallel compare against every stored key
  always_comb begin
    look_idx  = '0;
    match_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      look_match[i]  = valid_eff[i] && (key_r[i] == req.look_key);
      store_match[i] = valid_eff[i] && (key_r[i] == req.store_key);
      if (look_match[i]) begin
        look_idx = look_idx | IDX_W'(i);
      end
      if (store_match[i]) begin
        match_idx = match_idx | IDX_W'(i);
      end
    end
  end

  assign hit         = req.look_en && |(look_match & ~acked_eff);
  assign hit_idx     = look_idx;
  assign store_found = |store_match;
  assign store_idx   = store_found ? match_idx : ptr_eff;

  // flag and pointer update: mark the ack, then store the packet
  always_comb begin
    valid_nxt = valid_r;
    acked_nxt = acked_r;
    ptr_nxt   = ptr_r;
    if (req.upd) begin
      valid_nxt = valid_eff;
      acked_nxt = acked_eff;
      ptr_nxt   = ptr_eff;
      if (hit) begin
        acked_nxt[look_idx] = 1'b1;
      end
      valid_nxt[store_idx] = 1'b1;
      acked_nxt[store_idx] = 1'b0;
      if (!store_found) begin
        ptr_nxt = (ptr_eff == IDX_W'(ENTRIES - 1)) ? '0 : ptr_eff + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      acked_r <= '0;
      ptr_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      acked_r <= acked_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  // key storage
  always_ff @(posedge clk) begin
    if (req.upd) begin
      key_r[store_idx] <= req.store_key;
    end
  end

  // stored keys stay unique, so at most one entry matches
  a_look_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(look_match))
    else $error("ack lookup matched more than one entry");

  a_store_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(store_match))
    else $error("store lookup matched more than one entry");

  // a store always leaves its slot valid and unacknowledged
  a_store_lands: assert property (@(posedge clk) disable iff (!rst_n)
    req.upd |=> (valid_r[$past(store_idx)] && !acked_r[$past(store_idx)]))
    else $error("stored entry not valid or still acked");

endmodule
